### hw/rtl/tgt_pkg.sv
package tgt_pkg;

   // geometry
   localparam int MAX_DIM    = 256;
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int DIM_CNT_W  = IDX_W + 1;
   localparam int CFG_DIM_W  = 9;
   // Q8.8 offset: index*256 + 128 - centre, signed, with room for a 16-bit centre
   localparam int OFS_W      = ((IDX_W + 8 > 16) ? IDX_W + 8 : 16) + 2;
   localparam int PROD_W     = 2 * OFS_W;

   // accumulators and divider
   localparam int SUM_W      = 48;
   localparam int CNT_W      = 17;
   localparam int DIV_CNT_W  = $clog2(SUM_W);
   localparam int MOM_W      = 32;

   // ports
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 120;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE_X  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE_Y  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT    = 3'd4;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_DIVIDE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic wrap;
      logic pipe_busy;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/thresholded_gyration_tensor.sv
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/tready    | tdata: field_value
// rsp     | out       | rsp_tvalid/tready    | tdata: moment_xx, moment_yy, moment_xy,
//         |           |                      |        inside_count; tuser: empty_window
// csr     | in        | csr_we               | csr_index, csr_wdata
//
// Samples of a window are taken one per cycle. After the last sample of a
// window, req_tready stays low while the offset and multiply stages drain, the
// bit-serial divider runs and the result register loads once it is free. The
// result register frees the input side: the next window starts while a result
// waits on rsp_tready, only the next load waits.
// Reset is synchronous, active high, clears the sums and counters, restores config.
module thresholded_gyration_tensor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tgt_pkg::REQ_DATA_W-1:0]     req_tdata,  // [15:0] field_value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] moment_xx, [63:32] moment_yy, [95:64] moment_xy, [112:96] inside_count
   output logic [tgt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser,  // [0] empty_window
   input  logic                               csr_we,
   input  logic [tgt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tgt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tgt_pkg::cmd_type    cmd;
   tgt_pkg::status_type status;

   tgt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tgt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

### hw/rtl/tgt_ctrl.sv
module tgt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tgt_pkg::status_type status,
   output tgt_pkg::cmd_type    cmd
);

   tgt_pkg::ctrl_state_type state_ff;
   tgt_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgt_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tgt_pkg::ST_RUN: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.wrap) begin
                  state_in = tgt_pkg::ST_DRAIN;
               end
            end
         end
         tgt_pkg::ST_DRAIN: begin
            // wait for the last product to land in the sums
            if (!status.pipe_busy) begin
               cmd.div_start = 1'b1;
               state_in      = tgt_pkg::ST_DIVIDE;
            end
         end
         tgt_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = tgt_pkg::ST_EMIT;
            end
         end
         tgt_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = tgt_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = tgt_pkg::ST_RUN;
         end
      endcase
   end

endmodule

### hw/rtl/tgt_datapath.sv
module tgt_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tgt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tgt_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [tgt_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tgt_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tuser,
   input  tgt_pkg::cmd_type                     cmd,
   output tgt_pkg::status_type                  status
);

   localparam int IDX_W  = tgt_pkg::IDX_W;
   localparam int DCW    = tgt_pkg::DIM_CNT_W;
   localparam int OFS_W  = tgt_pkg::OFS_W;
   localparam int PROD_W = tgt_pkg::PROD_W;
   localparam int SUM_W  = tgt_pkg::SUM_W;
   localparam int CNT_W  = tgt_pkg::CNT_W;
   localparam int MOM_W  = tgt_pkg::MOM_W;
   localparam int EXT_W  = SUM_W + 1 - PROD_W;
   localparam int PAD_W  = tgt_pkg::RSP_DATA_W - 3 * MOM_W - CNT_W;
   localparam logic [tgt_pkg::DIV_CNT_W-1:0] DIV_LAST = tgt_pkg::DIV_CNT_W'(SUM_W - 1);

   localparam logic [SUM_W-1:0] SUM_U_MAX = {SUM_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_S_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [SUM_W-1:0] Q_U_MAX   = {{(SUM_W-MOM_W){1'b0}}, {MOM_W{1'b1}}};
   localparam logic [SUM_W-1:0] Q_S_MAX   = {{(SUM_W-MOM_W+1){1'b0}}, {(MOM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] Q_S_MIN   = {{(SUM_W-MOM_W){1'b0}}, 1'b1, {(MOM_W-1){1'b0}}};

   function automatic logic [DCW-1:0] clamp_dim(input logic [tgt_pkg::CFG_DIM_W-1:0] d);
      int dv;
      dv = int'(d);
      if (dv == 0) begin
         dv = 1;
      end else if (dv > tgt_pkg::MAX_DIM) begin
         dv = tgt_pkg::MAX_DIM;
      end
      return DCW'(dv);
   endfunction

   // configuration
   logic signed [15:0]                   threshold_ff;
   logic [15:0]                          centre_x_ff;
   logic [15:0]                          centre_y_ff;
   logic [tgt_pkg::CFG_DIM_W-1:0]        width_ff;
   logic [tgt_pkg::CFG_DIM_W-1:0]        height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 16'sd8192;
         centre_x_ff  <= '0;
         centre_y_ff  <= '0;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
      end else if (csr_we) begin
         case (csr_index)
            tgt_pkg::REG_THRESHOLD: threshold_ff <= $signed(csr_wdata);
            tgt_pkg::REG_CENTRE_X:  centre_x_ff  <= csr_wdata;
            tgt_pkg::REG_CENTRE_Y:  centre_y_ff  <= csr_wdata;
            tgt_pkg::REG_WIDTH:     width_ff     <= csr_wdata[tgt_pkg::CFG_DIM_W-1:0];
            tgt_pkg::REG_HEIGHT:    height_ff    <= csr_wdata[tgt_pkg::CFG_DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // scan position
   logic [IDX_W-1:0] outer_ff;
   logic [IDX_W-1:0] inner_ff;
   logic [DCW-1:0]   outer_next;
   logic [DCW-1:0]   inner_next;
   logic             outer_wrap;
   logic             inner_wrap;

   assign inner_next = {1'b0, inner_ff} + DCW'(1);
   assign outer_next = {1'b0, outer_ff} + DCW'(1);
   assign inner_wrap = inner_next >= clamp_dim(height_ff);
   assign outer_wrap = outer_next >= clamp_dim(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_ff <= '0;
         inner_ff <= '0;
      end else if (cmd.accept) begin
         if (!inner_wrap) begin
            inner_ff <= inner_next[IDX_W-1:0];
         end else begin
            inner_ff <= '0;
            outer_ff <= outer_wrap ? '0 : outer_next[IDX_W-1:0];
         end
      end
   end

   // stage 1: threshold and offsets
   logic                    s1_valid_ff;
   logic                    s1_inside_ff;
   logic signed [OFS_W-1:0] dx_ff;
   logic signed [OFS_W-1:0] dy_ff;
   logic signed [OFS_W-1:0] dx_in;
   logic signed [OFS_W-1:0] dy_in;

   assign dx_in = $signed({{(OFS_W-IDX_W-8){1'b0}}, outer_ff, 8'h80})
                - $signed({{(OFS_W-16){1'b0}}, centre_x_ff});
   assign dy_in = $signed({{(OFS_W-IDX_W-8){1'b0}}, inner_ff, 8'h80})
                - $signed({{(OFS_W-16){1'b0}}, centre_y_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.accept;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s1_inside_ff <= $signed(req_tdata) > threshold_ff;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
      end
   end

   // stage 2: products
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] p_xx_ff;
   logic signed [PROD_W-1:0] p_yy_ff;
   logic signed [PROD_W-1:0] p_xy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_xx_ff <= dx_ff * dx_ff;
      p_yy_ff <= dy_ff * dy_ff;
      p_xy_ff <= dx_ff * dy_ff;
   end

   // stage 3: saturating accumulation
   logic [SUM_W-1:0] sum_xx_ff;
   logic [SUM_W-1:0] sum_yy_ff;
   logic [SUM_W-1:0] sum_xy_ff;
   logic [CNT_W-1:0] hit_count_ff;
   logic [SUM_W:0]   add_xx;
   logic [SUM_W:0]   add_yy;
   logic [SUM_W:0]   add_xy;
   logic [SUM_W-1:0] sum_xx_in;
   logic [SUM_W-1:0] sum_yy_in;
   logic [SUM_W-1:0] sum_xy_in;

   always_comb begin
      add_xx = {1'b0, sum_xx_ff} + {{EXT_W{1'b0}}, p_xx_ff};
      add_yy = {1'b0, sum_yy_ff} + {{EXT_W{1'b0}}, p_yy_ff};
      add_xy = {sum_xy_ff[SUM_W-1], sum_xy_ff} + {{EXT_W{p_xy_ff[PROD_W-1]}}, p_xy_ff};
      sum_xx_in = add_xx[SUM_W] ? SUM_U_MAX : add_xx[SUM_W-1:0];
      sum_yy_in = add_yy[SUM_W] ? SUM_U_MAX : add_yy[SUM_W-1:0];
      if (add_xy[SUM_W] != add_xy[SUM_W-1]) begin
         sum_xy_in = add_xy[SUM_W] ? SUM_S_MIN : SUM_S_MAX;
      end else begin
         sum_xy_in = add_xy[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.div_start) begin
         sum_xx_ff    <= '0;
         sum_yy_ff    <= '0;
         sum_xy_ff    <= '0;
         hit_count_ff <= '0;
      end else if (s2_valid_ff) begin
         sum_xx_ff <= sum_xx_in;
         sum_yy_ff <= sum_yy_in;
         sum_xy_ff <= sum_xy_in;
         if (hit_count_ff != {CNT_W{1'b1}}) begin
            hit_count_ff <= hit_count_ff + CNT_W'(1);
         end
      end
   end

   // restoring divider, three lanes, one quotient bit per cycle
   logic [SUM_W-1:0]          quo_ff [3];
   logic [CNT_W-1:0]          rem_ff [3];
   logic [SUM_W-1:0]          quo_in [3];
   logic [CNT_W-1:0]          rem_in [3];
   logic [CNT_W-1:0]          divisor_ff;
   logic                      xy_neg_ff;
   logic                      div_busy_ff;
   logic [tgt_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   always_comb begin
      logic [CNT_W:0] shifted;
      for (int i = 0; i < 3; i++) begin
         shifted = {rem_ff[i], quo_ff[i][SUM_W-1]};
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in[i] = CNT_W'(shifted - {1'b0, divisor_ff});
            quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b1};
         end else begin
            rem_in[i] = shifted[CNT_W-1:0];
            quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + tgt_pkg::DIV_CNT_W'(1);
         if (div_cnt_ff == DIV_LAST) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff[0]  <= sum_xx_ff;
         quo_ff[1]  <= sum_yy_ff;
         quo_ff[2]  <= sum_xy_ff[SUM_W-1] ? (~sum_xy_ff + SUM_W'(1)) : sum_xy_ff;
         xy_neg_ff  <= sum_xy_ff[SUM_W-1];
         divisor_ff <= hit_count_ff;
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= '0;
         end
      end else if (div_busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            quo_ff[i] <= quo_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   // saturate quotients to the result ranges
   logic [MOM_W-1:0] mom_xx;
   logic [MOM_W-1:0] mom_yy;
   logic [MOM_W-1:0] mom_xy;
   logic             empty;

   assign empty  = divisor_ff == '0;
   assign mom_xx = (quo_ff[0] > Q_U_MAX) ? {MOM_W{1'b1}} : quo_ff[0][MOM_W-1:0];
   assign mom_yy = (quo_ff[1] > Q_U_MAX) ? {MOM_W{1'b1}} : quo_ff[1][MOM_W-1:0];

   always_comb begin
      logic [SUM_W-1:0] neg_q;
      neg_q = ~quo_ff[2] + SUM_W'(1);
      if (xy_neg_ff) begin
         mom_xy = (quo_ff[2] > Q_S_MIN) ? Q_S_MIN[MOM_W-1:0] : neg_q[MOM_W-1:0];
      end else begin
         mom_xy = (quo_ff[2] > Q_S_MAX) ? Q_S_MAX[MOM_W-1:0] : quo_ff[2][MOM_W-1:0];
      end
   end

   // result register
   logic                            rsp_valid_ff;
   logic [tgt_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic                            rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (empty) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= {{PAD_W{1'b0}}, divisor_ff, mom_xy, mom_yy, mom_xx};
         end
         rsp_user_ff <= empty;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign status.wrap      = inner_wrap && outer_wrap;
   assign status.pipe_busy = s1_valid_ff || s2_valid_ff;
   assign status.div_done  = div_busy_ff && (div_cnt_ff == DIV_LAST);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

### hw/rtl/tgt_checker.sv
module tgt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tgt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // an empty window carries all-zero moments and count
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("empty window with nonzero payload");

   // a non-empty window has a nonzero inside count
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[112:96] != '0)
      else $error("non-empty window with zero count");

   // no result right out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind thresholded_gyration_tensor tgt_checker u_tgt_checker (.*);

### bench/tgt_moment_checker.sv
`timescale 1ns / 100ps

module tgt_moment_checker
   import tgt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] field_value
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] moment_xx, [63:32] moment_yy, [95:64] moment_xy, [112:96] inside_count
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,   // [0] empty_window
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_results
);

   localparam longint unsigned SUM_U_LIMIT = (longint'(1) << SUM_W) - 1;
   localparam longint          SUM_S_HI    = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint          SUM_S_LO    = -SUM_S_HI - 1;
   localparam longint          MOM_S_HI    = 64'sd2147483647;
   localparam longint          MOM_S_LO    = -64'sd2147483648;
   localparam longint unsigned MOM_U_HI    = 64'hFFFF_FFFF;
   localparam int unsigned     HITS_LIMIT  = (1 << CNT_W) - 1;

   typedef struct {
      logic [MOM_W-1:0] xx;
      logic [MOM_W-1:0] yy;
      logic [MOM_W-1:0] xy;
      logic [CNT_W-1:0] count;
      logic             empty;
   } window_moments_type;

   window_moments_type moments_q[$];

   // settings as the block holds them
   logic signed [15:0]    level;
   logic [15:0]           centre_x;
   logic [15:0]           centre_y;
   logic [CFG_DIM_W-1:0]  width_code;
   logic [CFG_DIM_W-1:0]  height_code;

   // running window
   longint unsigned sum_xx;
   longint unsigned sum_yy;
   longint          sum_xy;
   int unsigned     hits;
   int unsigned     col;
   int unsigned     row;

   function automatic int unsigned extent(input logic [CFG_DIM_W-1:0] code);
      if (code == 0) return 1;
      if (code > MAX_DIM) return MAX_DIM;
      return code;
   endfunction

   task automatic clear_window();
      sum_xx = 0;
      sum_yy = 0;
      sum_xy = 0;
      hits   = 0;
      col    = 0;
      row    = 0;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic accumulate_sample(input logic [15:0] raw);
      longint             dx;
      longint             dy;
      longint unsigned    mxx;
      longint unsigned    myy;
      longint             mxy;
      window_moments_type m;
      if ($signed(raw) > level) begin
         dx = longint'(col) * 256 + 128 - longint'(centre_x);
         dy = longint'(row) * 256 + 128 - longint'(centre_y);
         sum_xx = sum_xx + longint'(dx * dx);
         if (sum_xx > SUM_U_LIMIT) sum_xx = SUM_U_LIMIT;
         sum_yy = sum_yy + longint'(dy * dy);
         if (sum_yy > SUM_U_LIMIT) sum_yy = SUM_U_LIMIT;
         sum_xy = sum_xy + dx * dy;
         if (sum_xy > SUM_S_HI) sum_xy = SUM_S_HI;
         if (sum_xy < SUM_S_LO) sum_xy = SUM_S_LO;
         if (hits < HITS_LIMIT) hits++;
      end
      // inner axis runs fastest; a shrunk extent wraps on this sample
      if (row + 1 < extent(height_code)) begin
         row++;
      end else begin
         row = 0;
         if (col + 1 < extent(width_code)) begin
            col++;
         end else begin
            if (hits == 0) begin
               m = '{xx: '0, yy: '0, xy: '0, count: '0, empty: 1'b1};
            end else begin
               mxx = sum_xx / longint'(hits);
               myy = sum_yy / longint'(hits);
               mxy = sum_xy / longint'(hits);
               if (mxx > MOM_U_HI) mxx = MOM_U_HI;
               if (myy > MOM_U_HI) myy = MOM_U_HI;
               if (mxy > MOM_S_HI) mxy = MOM_S_HI;
               if (mxy < MOM_S_LO) mxy = MOM_S_LO;
               m.xx    = mxx[MOM_W-1:0];
               m.yy    = myy[MOM_W-1:0];
               m.xy    = mxy[MOM_W-1:0];
               m.count = hits[CNT_W-1:0];
               m.empty = 1'b0;
            end
            moments_q.push_back(m);
            clear_window();
         end
      end
   endtask

   task automatic check_result();
      window_moments_type want;
      if (moments_q.size() == 0) begin
         report_mismatch("result with none expected", rsp_tdata[63:0], '0);
      end else begin
         want = moments_q.pop_front();
         if (rsp_tdata[31:0] !== want.xx)
            report_mismatch("moment_xx", rsp_tdata[31:0], want.xx);
         if (rsp_tdata[63:32] !== want.yy)
            report_mismatch("moment_yy", rsp_tdata[63:32], want.yy);
         if (rsp_tdata[95:64] !== want.xy)
            report_mismatch("moment_xy", rsp_tdata[95:64], want.xy);
         if (rsp_tdata[112:96] !== want.count)
            report_mismatch("inside_count", rsp_tdata[112:96], want.count);
         if (rsp_tuser !== want.empty)
            report_mismatch("empty_window", rsp_tuser, want.empty);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_window();
         moments_q.delete();
         level       = 16'sd8192;
         centre_x    = '0;
         centre_y    = '0;
         width_code  = CFG_DIM_W'(MAX_DIM);
         height_code = CFG_DIM_W'(MAX_DIM);
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_we) begin
            case (csr_index)
               REG_THRESHOLD: level       = csr_wdata;
               REG_CENTRE_X:  centre_x    = csr_wdata;
               REG_CENTRE_Y:  centre_y    = csr_wdata;
               REG_WIDTH:     width_code  = csr_wdata[CFG_DIM_W-1:0];
               REG_HEIGHT:    height_code = csr_wdata[CFG_DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) accumulate_sample(req_tdata);
      end
      pending_results = moments_q.size();
   end

endmodule

### bench/tb_thresholded_gyration_tensor.sv
`timescale 1ns / 100ps

module tb_thresholded_gyration_tensor;
   import tgt_pkg::*;

   localparam int     RANDOM_SAMPLES = 600;
   localparam int     DRAIN_CYCLES   = 80;
   localparam longint CYCLE_LIMIT    = 1_000_000;
   localparam int     CODE_TOP       = (1 << CFG_DIM_W) - 1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = REG_HEIGHT + 1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int     fail_count;
   int     pending_results;
   int     samples_sent = 0;
   longint cycle_count  = 0;
   bit     req_steady   = 1'b0;
   bit     rsp_steady   = 1'b0;

   always #1 clock = ~clock;

   thresholded_gyration_tensor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tgt_moment_checker moment_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_thresholded_gyration_tensor failed");
         $finish;
      end
   end

   task automatic send_sample(input logic [REQ_DATA_W-1:0] value);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      // scramble address and data while the enable is low
      csr_we    <= 1'b0;
      csr_index <= CSR_IDX_W'($urandom);
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
   endtask

   task automatic set_window(input logic [15:0] level, input logic [15:0] cx,
                             input logic [15:0] cy, input logic [CFG_DIM_W-1:0] w_code,
                             input logic [CFG_DIM_W-1:0] h_code);
      write_reg(REG_THRESHOLD, level);
      write_reg(REG_CENTRE_X, cx);
      write_reg(REG_CENTRE_Y, cy);
      write_reg(REG_WIDTH, {7'($urandom), w_code});
      write_reg(REG_HEIGHT, {7'($urandom), h_code});
   endtask

   // wait for every result, then let the pipeline and divider drain
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample(input logic [15:0] level);
      case ($urandom_range(0, 7))
         0: return level;
         1: return level + 16'd1;
         2: return level - 16'd1;
         3: return 16'h8000;
         4: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_centre(input int extent);
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, (extent * 256 > 65535) ? 65535 : extent * 256));
      endcase
   endfunction

   function automatic int pick_extent();
      case ($urandom_range(0, 24))
         0: return MAX_DIM;
         1: return $urandom_range(9, 40);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   // encode an extent, sometimes as zero or an oversized value that acts the same
   function automatic logic [CFG_DIM_W-1:0] dim_code(input int extent);
      if (extent == 1 && $urandom_range(0, 1)) return '0;
      if (extent == MAX_DIM && $urandom_range(0, 1))
         return CFG_DIM_W'($urandom_range(MAX_DIM + 1, CODE_TOP));
      return CFG_DIM_W'(extent);
   endfunction

   // result side: stall a random number of cycles per item
   initial begin
      int stall;
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 5);
         if (stall == 0) begin
            rsp_tready <= 1'b1;
            do @(posedge clock); while (!rsp_tvalid);
         end else begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (stall - 1) @(posedge clock);
            rsp_tready <= 1'b1;
            do @(posedge clock); while (!rsp_tvalid);
         end
      end
   end

   initial begin
      int          random_goal;
      int          w;
      int          h;
      int          windows;
      logic [15:0] level;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 256 x 256 window, level 0.5, centre at the origin
      send_sample(16'h2000);
      send_sample(16'h2001);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      settle();
      // shrink the window below the current inner position: it wraps at once
      write_reg(REG_WIDTH, 16'd2);
      write_reg(REG_HEIGHT, 16'd3);
      repeat (4) send_sample(16'($urandom));
      settle();

      // nothing can exceed the top level; zero extents act as one
      set_window(16'h7FFF, 16'h0000, 16'h0000, '0, '0);
      send_sample(16'h7FFF);
      settle();

      // far corner: largest offsets, product above the signed range
      set_window(16'h8000, 16'hFFFF, 16'hFFFF, 9'd1, 9'd1);
      send_sample(16'h8001);
      send_sample(16'h8000);
      settle();

      set_window(16'hFFFF, 16'h0180, 16'h0080, 9'd2, 9'd2);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      settle();

      // oversized width: only the last sample of the strip is inside
      set_window(16'h0000, 16'h0000, 16'hFFFF, CFG_DIM_W'(CODE_TOP), 9'd1);
      repeat (MAX_DIM - 1) send_sample({1'b1, 15'($urandom)});
      send_sample(16'h7FFF);
      settle();

      // writes to unused indexes must leave the settings alone
      set_window(16'd100, 16'h0300, 16'h0100, 9'd3, 9'd1);
      for (int i = REG_SPARE_LO; i < (1 << CSR_IDX_W); i++) begin
         write_reg(CSR_IDX_W'(i), CSR_DATA_W'($urandom));
      end
      repeat (3) send_sample(pick_sample(16'd100));

      random_goal = samples_sent + RANDOM_SAMPLES;
      while (samples_sent < random_goal) begin
         settle();
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         w = pick_extent();
         h = pick_extent();
         if (w * h > MAX_DIM) h = 1;
         case ($urandom_range(0, 7))
            0: level = 16'h8000;
            1: level = 16'h7FFF;
            2, 3: level = 16'($urandom_range(0, 16383)) - 16'd8192;
            default: level = 16'($urandom);
         endcase
         set_window(level, pick_centre(w), pick_centre(h), dim_code(w), dim_code(h));
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_IDX_W'($urandom_range(REG_SPARE_LO, (1 << CSR_IDX_W) - 1)),
                      CSR_DATA_W'($urandom));
         windows = (w * h > 64) ? 1 : $urandom_range(1, 4);
         repeat (windows * w * h) send_sample(pick_sample(level));
         if (w * h > 1 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, w * h - 1)) send_sample(pick_sample(level));
            settle();
            // move level and centre mid-window, then shrink to one position
            // so the next sample closes the window
            level = 16'($urandom);
            write_reg(REG_THRESHOLD, level);
            write_reg(REG_CENTRE_X, 16'($urandom));
            write_reg(REG_CENTRE_Y, 16'($urandom));
            write_reg(REG_WIDTH, {7'($urandom), dim_code(1)});
            write_reg(REG_HEIGHT, {7'($urandom), dim_code(1)});
            send_sample(pick_sample(level));
         end
      end
      settle();

      if (fail_count == 0 && pending_results == 0) begin
         $display("tb_thresholded_gyration_tensor passed");
      end else begin
         $display("tb_thresholded_gyration_tensor failed");
      end
      $finish;
   end

endmodule
